### src/fba_pkg.sv
// Shared constants and types for the frame bitmap allocator.
`default_nettype none

package fba_pkg;

  // Command codes
  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_CLEAR = 3'd1;
  localparam logic [2:0] CMD_TEST  = 3'd2;
  localparam logic [2:0] CMD_FIND  = 3'd3;
  localparam logic [2:0] CMD_ALLOC = 3'd4;
  localparam logic [2:0] CMD_FREE  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_HAS_FRAME = 2'd1;
  localparam logic [1:0] ST_NO_FRAME  = 2'd2;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 28;
  localparam int FRAME_W = 16;
  localparam int STAT_W  = 2;

  // 4 KiB frames
  localparam int FRAME_SHIFT = 12;

  // Configuration register
  localparam int                 FRAME_COUNT_W     = 17;
  localparam logic [16:0]        FRAME_COUNT_RESET = 17'd65536;
  localparam int                 PADDR_W           = 3;
  localparam int                 PDATA_W           = 32;
  localparam logic               REG_FRAME_COUNT   = 1'b0;

  // Flags from the word search unit
  typedef struct packed {
    logic hit;       // a free frame below the limit lies in this word
    logic past_end;  // the word starts at or beyond the limit
  } srch_flags_t;

endpackage

`default_nettype wire

### src/fba_ram.sv
// Single-port-write, single-port-read bitmap memory with registered read data.
`default_nettype none

module fba_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/fba_word_search.sv
// Lowest free frame in one bitmap word, masked to frames below the limit.
`default_nettype none

module fba_word_search import fba_pkg::*; #(
  parameter int BPW   = 32,
  parameter int BIT_W = 5,
  parameter int CNT_W = 18
) (
  input  wire logic [BPW-1:0]   word,
  input  wire logic [CNT_W-1:0] base,
  input  wire logic [CNT_W-1:0] limit,
  output srch_flags_t           flags,
  output logic [BIT_W-1:0]      idx
);

  logic [CNT_W-1:0] rem;
  logic [BPW-1:0]   mask;
  logic [BPW-1:0]   free_bits;

  // frames of this word that lie below the limit
  always_comb begin
    rem = limit - base;
    flags.past_end = (base >= limit);
    if (flags.past_end) begin
      mask = '0;
    end else if (rem >= CNT_W'(BPW)) begin
      mask = '1;
    end else begin
      mask = ~({BPW{1'b1}} << rem[BIT_W-1:0]);
    end
    free_bits = ~word & mask;
    flags.hit = |free_bits;
  end

  // priority encode, lowest bit wins
  always_comb begin
    idx = '0;
    for (int b = BPW - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        idx = BIT_W'(b);
      end
    end
  end

endmodule

`default_nettype wire

### src/fba_apb_regs.sv
// APB register block holding the managed frame count.
`default_nettype none

module fba_apb_regs import fba_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [PDATA_W-1:0]       pwdata,
  output logic      [PDATA_W-1:0]       prdata,
  output logic                          pready,
  output logic      [FRAME_COUNT_W-1:0] frame_count
);

  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_FRAME_COUNT);

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      frame_count <= pwdata[FRAME_COUNT_W-1:0];
    end
  end

  // read back
  assign prdata = reg_sel ? PDATA_W'(frame_count) : '0;

endmodule

`default_nettype wire

### src/frame_bitmap_allocator_core.sv
// Frame bitmap allocator: command sequencer around the bitmap memory.
//
// Usage: one command beat enters on cmd_valid/cmd_stall and yields exactly one
// result beat on res_valid/res_stall. Set, clear, test and free address one
// bitmap word: read, then modify and write back (test only reads). Find and
// allocate stream the bitmap words through the memory read port, one word per
// cycle, and stop at the lowest free frame below min(frame_count, MAX_FRAMES).
// Set, clear, test and free pass through the read, modify and emit states; a
// refused or unused command goes straight to emit; find and allocate scan
// until a hit, the limit or the last word, then emit.
// One item is in flight at a time; the next beat is taken the cycle after the
// result is loaded. The scan rate is set by the single memory read port.
// Reset: rst clears control state, then a clearing pass writes zero to every
// bitmap word (WORD_COUNT words, 2048 by default), one per cycle, with
// cmd_stall high. The frame_count register resets to 65536 and may be written
// through APB at any time the block is idle.
// Receiver stall: the result register holds its beat; a new command is still
// accepted and worked on, and waits for the result register before finishing.
`default_nettype none

module frame_bitmap_allocator_core import fba_pkg::*; #(
  parameter int MAX_FRAMES    = 65536,
  parameter int BITS_PER_WORD = 32     // power of two, 8 to 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // command channel
  input  wire logic                  cmd_valid,
  output logic                       cmd_stall,
  input  wire logic [CMD_W-1:0]      command,
  input  wire logic [ADDR_W-1:0]     byte_address,
  input  wire logic [FRAME_W-1:0]    entry_frame,
  input  wire logic                  supervisor,
  input  wire logic                  read_write,
  // result channel
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output logic [STAT_W-1:0]          status,
  output logic [FRAME_W-1:0]         frame_number,
  output logic                       frame_busy,
  output logic                       entry_present,
  output logic                       entry_user,
  output logic                       entry_writable,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]    pwdata,
  output logic      [PDATA_W-1:0]    prdata,
  output logic                       pready
);

  localparam int WORD_COUNT = (MAX_FRAMES + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(BITS_PER_WORD);
  localparam int LIM_BITS   = $clog2(MAX_FRAMES + 1);
  localparam int CNT_W      = ((LIM_BITS > FRAME_COUNT_W) ? LIM_BITS : FRAME_COUNT_W) + 1;
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_COUNT - 1);
  localparam logic [CNT_W-1:0]   MAX_LIM   = CNT_W'(MAX_FRAMES);

  // sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_MODIFY = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]               state;
  logic [CMD_W-1:0]         op;
  logic [FRAME_W-1:0]       tgt;
  logic                     kern;
  logic                     wrt;
  logic [WADDR_W-1:0]       clr_addr;
  logic [WADDR_W-1:0]       scan_addr;
  logic                     scan_last;
  logic [WADDR_W-1:0]       chk_addr;
  logic                     chk_valid;

  logic [STAT_W-1:0]        fin_status;
  logic [FRAME_W-1:0]       fin_frame;
  logic                     fin_busy;
  logic                     fin_present;
  logic                     fin_user;
  logic                     fin_writable;

  logic [FRAME_COUNT_W-1:0] frame_count;
  logic [CNT_W-1:0]         count_ext;
  logic [CNT_W-1:0]         limit;

  logic                     cmd_take;
  logic [FRAME_W-1:0]       addr_frame;
  logic [FRAME_W-1:0]       new_tgt;
  logic                     new_tgt_ok;
  logic [CNT_W-1:0]         tgt_ext;
  logic [WADDR_W-1:0]       tgt_word;
  logic [BIT_W-1:0]         tgt_bit;
  logic [BITS_PER_WORD-1:0] tgt_mask;

  logic [CNT_W-1:0]         chk_base;
  srch_flags_t              srch;
  logic [BIT_W-1:0]         srch_idx;
  logic [CNT_W-1:0]         found_frame;
  logic [BITS_PER_WORD-1:0] found_mask;
  logic                     scan_hit;
  logic                     scan_fail;
  logic                     res_free;

  logic                     ram_we;
  logic [WADDR_W-1:0]       ram_waddr;
  logic [BITS_PER_WORD-1:0] ram_wdata;
  logic                     ram_re;
  logic [WADDR_W-1:0]       ram_raddr;
  logic [BITS_PER_WORD-1:0] ram_rdata;

  fba_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .frame_count (frame_count)
  );

  fba_ram #(
    .DEPTH (WORD_COUNT),
    .AW    (WADDR_W),
    .DW    (BITS_PER_WORD)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fba_word_search #(
    .BPW   (BITS_PER_WORD),
    .BIT_W (BIT_W),
    .CNT_W (CNT_W)
  ) u_search (
    .word  (ram_rdata),
    .base  (chk_base),
    .limit (limit),
    .flags (srch),
    .idx   (srch_idx)
  );

  // search limit: frame count clipped to the bitmap size
  assign count_ext = CNT_W'(frame_count);
  assign limit     = (count_ext > MAX_LIM) ? MAX_LIM : count_ext;

  // input decode
  assign cmd_stall  = (state != S_IDLE);
  assign cmd_take   = cmd_valid && !cmd_stall;
  assign addr_frame = byte_address[ADDR_W-1:FRAME_SHIFT];
  assign new_tgt    = (command == CMD_FREE) ? entry_frame : addr_frame;
  assign new_tgt_ok = (CNT_W'(new_tgt) < MAX_LIM);

  // word and bit of the addressed frame
  assign tgt_ext  = CNT_W'(tgt);
  assign tgt_word = tgt_ext[BIT_W +: WADDR_W];
  assign tgt_bit  = tgt_ext[BIT_W-1:0];
  assign tgt_mask = BITS_PER_WORD'(1) << tgt_bit;

  // scan evaluation of the word now on the read data
  assign chk_base    = CNT_W'(chk_addr) << BIT_W;
  assign found_frame = chk_base + CNT_W'(srch_idx);
  assign found_mask  = BITS_PER_WORD'(1) << srch_idx;
  assign scan_hit    = chk_valid && !srch.past_end && srch.hit;
  assign scan_fail   = chk_valid && (srch.past_end || (!srch.hit && chk_addr == LAST_WORD));

  assign res_free = !res_valid || !res_stall;

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tgt_word;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = tgt_word;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_MODIFY: begin
        case (op) inside
          CMD_SET: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | tgt_mask;
          end
          CMD_CLEAR, CMD_FREE: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~tgt_mask;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        ram_re    = !scan_last;
        ram_raddr = scan_addr;
        if (scan_hit && op == CMD_ALLOC) begin
          ram_we    = 1'b1;
          ram_waddr = chk_addr;
          ram_wdata = ram_rdata | found_mask;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      scan_addr <= '0;
      scan_last <= 1'b0;
      chk_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // result valid: raised when a beat is loaded, dropped once taken
      if (state == S_EMIT && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_take) begin
            op           <= command;
            tgt          <= new_tgt;
            kern         <= supervisor;
            wrt          <= read_write;
            fin_status   <= (command == CMD_ALLOC && entry_frame != '0) ? ST_HAS_FRAME
                                                                        : ST_OK;
            fin_frame    <= '0;
            fin_busy     <= 1'b0;
            fin_present  <= 1'b0;
            fin_user     <= 1'b0;
            fin_writable <= 1'b0;
            scan_addr    <= '0;
            scan_last    <= 1'b0;
            chk_valid    <= 1'b0;
            case (command) inside
              CMD_SET, CMD_CLEAR, CMD_TEST, CMD_FREE: begin
                state <= new_tgt_ok ? S_READ : S_EMIT;
              end
              CMD_FIND: begin
                state <= S_SCAN;
              end
              CMD_ALLOC: begin
                // entry already mapped: refuse at once
                state <= (entry_frame != '0) ? S_EMIT : S_SCAN;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          if (op == CMD_TEST) begin
            fin_busy <= ram_rdata[tgt_bit];
          end
          state <= S_EMIT;
        end
        S_SCAN: begin
          // issue side: one word address per cycle
          if (!scan_last) begin
            chk_addr  <= scan_addr;
            chk_valid <= 1'b1;
            if (scan_addr == LAST_WORD) begin
              scan_last <= 1'b1;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end else begin
            chk_valid <= 1'b0;
          end
          // check side: word read in the previous cycle
          if (scan_hit) begin
            fin_frame <= found_frame[FRAME_W-1:0];
            if (op == CMD_ALLOC) begin
              fin_present  <= 1'b1;
              fin_user     <= !kern;
              fin_writable <= wrt;
            end
            state <= S_EMIT;
          end else if (scan_fail) begin
            fin_status <= ST_NO_FRAME;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_EMIT && res_free) begin
      status         <= fin_status;
      frame_number   <= fin_frame;
      frame_busy     <= fin_busy;
      entry_present  <= fin_present;
      entry_user     <= fin_user;
      entry_writable <= fin_writable;
    end
  end

endmodule

`default_nettype wire

### src/fba_checker.sv
// Port-level checks on the frame bitmap allocator, bound to the top level.
`default_nettype none

module fba_checker import fba_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_stall,
  input wire logic               res_valid,
  input wire logic               res_stall,
  input wire logic [STAT_W-1:0]  status,
  input wire logic [FRAME_W-1:0] frame_number,
  input wire logic               frame_busy,
  input wire logic               entry_present,
  input wire logic               entry_user,
  input wire logic               entry_writable
);

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid &&
      $stable({status, frame_number, frame_busy, entry_present, entry_user, entry_writable}))
    else $error("result beat changed while stalled");

  // after reset: no result, and commands are held off for the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) && !rst |-> cmd_stall && !res_valid)
    else $error("block not quiet after reset");

  // a refused command carries no frame and no entry bits
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_OK |->
      frame_number == '0 && !frame_busy && !entry_present && !entry_user && !entry_writable)
    else $error("refused command carries data");

  // entry bits only come with a successful allocate, never with a test answer
  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && (entry_user || entry_writable) |-> entry_present && !frame_busy)
    else $error("entry bits without present");

endmodule

bind frame_bitmap_allocator_core fba_checker u_fba_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_stall      (cmd_stall),
  .res_valid      (res_valid),
  .res_stall      (res_stall),
  .status         (status),
  .frame_number   (frame_number),
  .frame_busy     (frame_busy),
  .entry_present  (entry_present),
  .entry_user     (entry_user),
  .entry_writable (entry_writable)
);

`default_nettype wire
